@@ src/char_lcd_bus_sequencer_defines.svh @@
// assertion macros for the char lcd bus sequencer checker
// no dependencies; included by files that assert
`ifndef CHAR_LCD_BUS_SEQUENCER_DEFINES_SVH
`define CHAR_LCD_BUS_SEQUENCER_DEFINES_SVH

// property checked at every edge, reset included
`define CLBS_ASSERT(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("clbs check failed");

// property checked only outside reset
`define CLBS_ASSERT_RST(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("clbs check failed");

`endif

@@ src/clbs_pkg.sv @@
// shared types, codes and constants of the char lcd bus sequencer
// no dependencies
package clbs_pkg;

    localparam int TICK_W = 20;
    localparam int CFG_DATA_W = 20;
    localparam int CFG_INDEX_W = 3;
    localparam int QUEUE_DEPTH_DEFAULT = 4;
    localparam int PHASE_W = 3;

    localparam logic [7:0] CMD_CLEAR        = 8'h01;
    localparam logic [7:0] CMD_HOME4        = 8'h02;
    localparam logic [7:0] CMD_DISPLAY_ON   = 8'h0C;
    localparam logic [7:0] CMD_FUNCTION_SET = 8'h20;
    localparam logic [7:0] CMD_DDRAM        = 8'h80;
    localparam logic [7:0] NIBBLE_HI_MASK   = 8'hF0;
    localparam logic [7:0] NIBBLE_LO_MASK   = 8'h0F;

    localparam logic [3:0][7:0] ROW_BASE = {8'h50, 8'h10, 8'h40, 8'h00};

    localparam logic [TICK_W-1:0] PHASE_TICKS_RESET = 20'd50000;

    // last phase index of one byte transfer
    localparam logic [PHASE_W-1:0] PHASE_LAST_8BIT = 3'd3;
    localparam logic [PHASE_W-1:0] PHASE_LAST_4BIT = 3'd5;
    localparam logic [PHASE_W-1:0] PHASE_E_HIGH_A  = 3'd1;
    localparam logic [PHASE_W-1:0] PHASE_PLACE_HI  = 3'd2;
    localparam logic [PHASE_W-1:0] PHASE_PLACE_LO  = 3'd4;

    typedef enum logic [2:0] {
        OP_INIT    = 3'd0,
        OP_INSTR   = 3'd1,
        OP_DATA    = 3'd2,
        OP_CLEAR   = 3'd3,
        OP_SET_POS = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        CFG_EIGHT_BIT   = 3'd0,
        CFG_DUAL_LINE   = 3'd1,
        CFG_TALL_FONT   = 3'd2,
        CFG_CURSOR_ON   = 3'd3,
        CFG_BLINK_ON    = 3'd4,
        CFG_PHASE_TICKS = 3'd5
    } cfg_index_t;

    typedef enum logic [1:0] {
        FS_IDLE,
        FS_FSET,
        FS_DON,
        FS_CLEAR
    } front_state_t;

    typedef struct packed {
        logic [2:0] operation;
        logic [7:0] value;
        logic [1:0] row;
        logic [5:0] column;
    } lcd_in_t;

    typedef struct packed {
        logic       reg_select;
        logic       read_write;
        logic       enable;
        logic [7:0] bus_value;
        logic       last;
    } lcd_out_t;

    typedef struct packed {
        logic              eight_bit_mode;
        logic              dual_line;
        logic              tall_font;
        logic              cursor_on;
        logic              blink_on;
        logic [TICK_W-1:0] phase_ticks;
    } cfg_t;

    // one byte transfer to the lcd
    typedef struct packed {
        logic       reg_select;
        logic [7:0] byte_val;
        logic       last;
    } xfer_t;

    typedef struct packed {
        logic push_ready;
        logic pop_valid;
    } q_status_t;

endpackage

@@ src/clbs_front.sv @@
// front end: accepts commands and splits them into byte transfers
// depends on clbs_pkg
module clbs_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  clbs_pkg::cfg_t      cfg,
    input  logic                s_valid,
    output logic                s_ready,
    input  clbs_pkg::lcd_in_t   s_data,
    input  clbs_pkg::q_status_t q_status,
    output logic                push_valid,
    output clbs_pkg::xfer_t     push_entry
);

    clbs_pkg::front_state_t state_reg, state_next;
    logic [7:0] fset_byte;
    logic [7:0] don_byte;
    logic [7:0] pos_addr;

    assign fset_byte = clbs_pkg::CMD_FUNCTION_SET
                     | {3'b000, cfg.eight_bit_mode, cfg.dual_line, cfg.tall_font, 2'b00};
    assign don_byte  = clbs_pkg::CMD_DISPLAY_ON | {6'b000000, cfg.cursor_on, cfg.blink_on};
    assign pos_addr  = clbs_pkg::CMD_DDRAM
                     | (clbs_pkg::ROW_BASE[s_data.row] + {2'b00, s_data.column});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= clbs_pkg::FS_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        push_valid = 1'b0;
        push_entry = '0;
        unique case (state_reg)
            clbs_pkg::FS_IDLE: begin
                s_ready = q_status.push_ready;
                if (s_valid && q_status.push_ready) begin
                    unique case (s_data.operation)
                        clbs_pkg::OP_INIT: begin
                            push_valid = 1'b1;
                            if (cfg.eight_bit_mode) begin
                                push_entry = '{reg_select: 1'b0, byte_val: fset_byte,
                                               last: 1'b0};
                                state_next = clbs_pkg::FS_DON;
                            end else begin
                                push_entry = '{reg_select: 1'b0,
                                               byte_val: clbs_pkg::CMD_HOME4, last: 1'b0};
                                state_next = clbs_pkg::FS_FSET;
                            end
                        end
                        clbs_pkg::OP_INSTR: begin
                            push_valid = 1'b1;
                            push_entry = '{reg_select: 1'b0, byte_val: s_data.value,
                                           last: 1'b1};
                        end
                        clbs_pkg::OP_DATA: begin
                            push_valid = 1'b1;
                            push_entry = '{reg_select: 1'b1, byte_val: s_data.value,
                                           last: 1'b1};
                        end
                        clbs_pkg::OP_CLEAR: begin
                            push_valid = 1'b1;
                            push_entry = '{reg_select: 1'b0,
                                           byte_val: clbs_pkg::CMD_CLEAR, last: 1'b1};
                        end
                        clbs_pkg::OP_SET_POS: begin
                            push_valid = 1'b1;
                            push_entry = '{reg_select: 1'b0, byte_val: pos_addr,
                                           last: 1'b1};
                        end
                        default: begin
                            // unknown operation is dropped
                        end
                    endcase
                end
            end
            clbs_pkg::FS_FSET: begin
                push_valid = 1'b1;
                push_entry = '{reg_select: 1'b0, byte_val: fset_byte, last: 1'b0};
                if (q_status.push_ready) begin
                    state_next = clbs_pkg::FS_DON;
                end
            end
            clbs_pkg::FS_DON: begin
                push_valid = 1'b1;
                push_entry = '{reg_select: 1'b0, byte_val: don_byte, last: 1'b0};
                if (q_status.push_ready) begin
                    state_next = clbs_pkg::FS_CLEAR;
                end
            end
            clbs_pkg::FS_CLEAR: begin
                push_valid = 1'b1;
                push_entry = '{reg_select: 1'b0, byte_val: clbs_pkg::CMD_CLEAR, last: 1'b1};
                if (q_status.push_ready) begin
                    state_next = clbs_pkg::FS_IDLE;
                end
            end
            default: begin
                state_next = clbs_pkg::FS_IDLE;
            end
        endcase
    end

endmodule

@@ src/clbs_queue.sv @@
// short transfer queue between front and back end
// depends on clbs_pkg
module clbs_queue #(
    parameter int DEPTH = clbs_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push_valid,
    input  clbs_pkg::xfer_t      push_entry,
    input  logic                 pop_ready,
    output clbs_pkg::xfer_t      pop_entry,
    output clbs_pkg::q_status_t  q_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    clbs_pkg::xfer_t entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic push;
    logic pop;

    assign q_status.push_ready = (count_reg != CNT_W'(DEPTH));
    assign q_status.pop_valid  = (count_reg != '0);
    assign push = push_valid && q_status.push_ready;
    assign pop  = pop_ready && q_status.pop_valid;
    assign pop_entry = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

@@ src/clbs_back.sv @@
// back end: plays each byte transfer as timed pin phases
// depends on clbs_pkg
module clbs_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  clbs_pkg::cfg_t      cfg,
    input  clbs_pkg::q_status_t q_status,
    input  clbs_pkg::xfer_t     pop_entry,
    output logic                pop_ready,
    output logic                m_valid,
    input  logic                m_ready,
    output clbs_pkg::lcd_out_t  m_data
);

    localparam int PW = clbs_pkg::PHASE_W;
    localparam int TW = clbs_pkg::TICK_W;

    logic                     active_reg, active_next;
    clbs_pkg::xfer_t          xfer_reg, xfer_next;
    logic [PW-1:0]            phase_reg, phase_next;
    logic [TW-1:0]            tick_reg, tick_next;
    logic [7:0]               held_bus_reg, held_bus_next;
    logic                     m_valid_reg, m_valid_next;
    clbs_pkg::lcd_out_t       m_data_reg, m_data_next;

    logic       tick_done;
    logic       emit;
    logic       final_phase;
    logic [7:0] shown_bus;
    logic [7:0] hi_nibble;
    logic [7:0] lo_nibble;
    clbs_pkg::lcd_out_t phase_out;

    assign tick_done = ({1'b0, tick_reg} + (TW+1)'(1)) >= {1'b0, cfg.phase_ticks};
    assign emit = active_reg && tick_done && (!m_valid_reg || m_ready);
    assign final_phase = (phase_reg == (cfg.eight_bit_mode ? clbs_pkg::PHASE_LAST_8BIT
                                                           : clbs_pkg::PHASE_LAST_4BIT));
    assign pop_ready = !active_reg || (emit && final_phase);

    assign shown_bus = cfg.eight_bit_mode ? held_bus_reg
                                          : (held_bus_reg & clbs_pkg::NIBBLE_LO_MASK);
    assign hi_nibble = (xfer_reg.byte_val & clbs_pkg::NIBBLE_HI_MASK) >> 4;
    assign lo_nibble = xfer_reg.byte_val & clbs_pkg::NIBBLE_LO_MASK;

    always_comb begin
        phase_out.reg_select = xfer_reg.reg_select;
        phase_out.read_write = 1'b0;
        phase_out.last       = xfer_reg.last && final_phase;
        phase_out.enable     = (phase_reg == clbs_pkg::PHASE_E_HIGH_A)
                            || (phase_reg == clbs_pkg::PHASE_PLACE_HI)
                            || (phase_reg == clbs_pkg::PHASE_PLACE_LO);
        if (phase_reg < clbs_pkg::PHASE_PLACE_HI) begin
            phase_out.bus_value = shown_bus;
        end else if (cfg.eight_bit_mode) begin
            phase_out.bus_value = xfer_reg.byte_val;
        end else if (phase_reg < clbs_pkg::PHASE_PLACE_LO) begin
            phase_out.bus_value = hi_nibble;
        end else begin
            phase_out.bus_value = lo_nibble;
        end
    end

    always_comb begin
        active_next   = active_reg;
        xfer_next     = xfer_reg;
        phase_next    = phase_reg;
        tick_next     = tick_reg;
        held_bus_next = held_bus_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;

        if (active_reg && !tick_done) begin
            tick_next = tick_reg + 1'b1;
        end
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (emit) begin
            m_valid_next = 1'b1;
            m_data_next  = phase_out;
            phase_next   = phase_reg + 1'b1;
            tick_next    = '0;
            if (phase_reg == clbs_pkg::PHASE_PLACE_HI ||
                phase_reg == clbs_pkg::PHASE_PLACE_LO) begin
                held_bus_next = phase_out.bus_value;
            end
            if (final_phase) begin
                active_next = 1'b0;
            end
        end
        if (pop_ready && q_status.pop_valid) begin
            active_next = 1'b1;
            xfer_next   = pop_entry;
            phase_next  = '0;
            tick_next   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg   <= 1'b0;
            phase_reg    <= '0;
            tick_reg     <= '0;
            held_bus_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            active_reg   <= active_next;
            phase_reg    <= phase_next;
            tick_reg     <= tick_next;
            held_bus_reg <= held_bus_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        xfer_reg   <= xfer_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

@@ src/char_lcd_bus_sequencer.sv @@
// top level of the character lcd write bus sequencer
// depends on clbs_pkg, clbs_front, clbs_queue, clbs_back
//
// s_ channel takes one command (init, instruction, data char, clear, set
// position) per transfer; m_ channel gives one transfer per lcd pin phase.
// a byte goes as 4 phases in 8-bit mode and 6 phases in 4-bit mode; init
// gives 3 or 4 bytes, the last phase of a command carries last.
// each phase waits on the phase timer in the back end, set by phase_ticks,
// before it is shown; bytes go through the transfer queue and phases through
// the output register. the front end takes a command every cycle while the
// transfer queue has room; init holds s_ready low while its bytes are queued.
// when m_ready is low the current phase holds on the output and the timer
// stops after it runs out; the front keeps filling the queue.
// reset clears the queue, the output and the held bus value, and loads the
// register defaults; configuration is written on cfg_wr_en with no wait.
module char_lcd_bus_sequencer #(
    parameter int QUEUE_DEPTH = clbs_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [clbs_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [clbs_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  clbs_pkg::lcd_in_t                  s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output clbs_pkg::lcd_out_t                 m_data
);

    clbs_pkg::cfg_t      cfg_reg, cfg_next;
    clbs_pkg::q_status_t q_status;
    clbs_pkg::xfer_t     push_entry;
    clbs_pkg::xfer_t     pop_entry;
    logic                push_valid;
    logic                pop_ready;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                clbs_pkg::CFG_EIGHT_BIT:   cfg_next.eight_bit_mode = cfg_wdata[0];
                clbs_pkg::CFG_DUAL_LINE:   cfg_next.dual_line      = cfg_wdata[0];
                clbs_pkg::CFG_TALL_FONT:   cfg_next.tall_font      = cfg_wdata[0];
                clbs_pkg::CFG_CURSOR_ON:   cfg_next.cursor_on      = cfg_wdata[0];
                clbs_pkg::CFG_BLINK_ON:    cfg_next.blink_on       = cfg_wdata[0];
                clbs_pkg::CFG_PHASE_TICKS: begin
                    cfg_next.phase_ticks = cfg_wdata[clbs_pkg::TICK_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.eight_bit_mode <= 1'b0;
            cfg_reg.dual_line      <= 1'b1;
            cfg_reg.tall_font      <= 1'b0;
            cfg_reg.cursor_on      <= 1'b0;
            cfg_reg.blink_on       <= 1'b0;
            cfg_reg.phase_ticks    <= clbs_pkg::PHASE_TICKS_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    clbs_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .q_status   (q_status),
        .push_valid (push_valid),
        .push_entry (push_entry)
    );

    clbs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry),
        .q_status   (q_status)
    );

    clbs_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .q_status  (q_status),
        .pop_entry (pop_entry),
        .pop_ready (pop_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

@@ src/clbs_checker.sv @@
// port level checks of the char lcd bus sequencer, bound to the top level
// depends on clbs_pkg and char_lcd_bus_sequencer_defines.svh
`include "char_lcd_bus_sequencer_defines.svh"

module clbs_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input clbs_pkg::lcd_out_t m_data
);

    `CLBS_ASSERT(a_reset_clears_out, aclk, !aresetn |=> !m_valid)
    `CLBS_ASSERT_RST(a_out_holds, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_data))
    `CLBS_ASSERT_RST(a_write_only, aclk, aresetn, m_valid |-> !m_data.read_write)

endmodule

bind char_lcd_bus_sequencer clbs_checker u_clbs_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

@@ tb/tb_char_lcd_bus_sequencer.sv @@
// testbench for char_lcd_bus_sequencer: lcd commands in, pin phases out
// depends on clbs_pkg and the char_lcd_bus_sequencer rtl
// phases are predicted per command and checked in order, under random pacing
`timescale 1ns / 100ps

module tb_char_lcd_bus_sequencer;
    import clbs_pkg::*;

    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES = 600;
    localparam logic [2:0] OP_RSVD_A = 3'd5;
    localparam logic [2:0] OP_RSVD_B = 3'd6;
    localparam logic [2:0] OP_RSVD_C = 3'd7;
    localparam logic [TICK_W-1:0] TICKS_MAX = 20'hFFFFF;

    typedef struct packed {
        logic       is_cfg;
        cfg_index_t reg_index;
        logic [CFG_DATA_W-1:0] wdata;
        logic [2:0] op;
        logic [7:0] value;
        logic [1:0] row;
        logic [5:0] column;
        logic       typed;
        logic [4:0] exp_n;
        logic [7:0] exp_bus;
    } step_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;
    logic                   s_valid;
    logic                   s_ready;
    lcd_in_t                s_data;
    logic                   m_valid;
    logic                   m_ready;
    lcd_out_t               m_data;

    cfg_t       lcd_cfg;
    logic [7:0] held_bus;
    lcd_out_t   pending_phases[$];
    lcd_out_t   want;
    int         fail_count = 0;
    int         stall_pct = 0;
    int         gap_max = 0;
    int         burst_left = 0;
    bit         hold_req = 1'b0;

    char_lcd_bus_sequencer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin : watchdog
        #20ms;
        $display("tb: failure");
        $finish;
    end

    // expected pin phases
    task automatic emit(input logic rs, input logic en, input logic [7:0] bus);
        lcd_out_t p;
        p.reg_select = rs;
        p.read_write = 1'b0;
        p.enable = en;
        p.bus_value = bus;
        p.last = 1'b0;
        pending_phases.push_back(p);
    endtask

    task automatic byte_phases(input logic rs, input logic [7:0] b);
        logic [7:0] shown;
        shown = lcd_cfg.eight_bit_mode ? held_bus : (held_bus & NIBBLE_LO_MASK);
        emit(rs, 1'b0, shown);
        emit(rs, 1'b1, shown);
        if (lcd_cfg.eight_bit_mode) begin
            held_bus = b;
            emit(rs, 1'b1, held_bus);
            emit(rs, 1'b0, held_bus);
        end else begin
            held_bus = (b & NIBBLE_HI_MASK) >> 4;
            emit(rs, 1'b1, held_bus);
            emit(rs, 1'b0, held_bus);
            held_bus = b & NIBBLE_LO_MASK;
            emit(rs, 1'b1, held_bus);
            emit(rs, 1'b0, held_bus);
        end
    endtask

    task automatic plan_bus_phases(input lcd_in_t cmd, output int n,
                                   output logic [7:0] last_bus);
        int before_n;
        logic [7:0] addr;
        lcd_out_t tail;
        before_n = pending_phases.size();
        last_bus = 8'h00;
        case (cmd.operation)
            OP_INIT: begin
                if (!lcd_cfg.eight_bit_mode) byte_phases(1'b0, CMD_HOME4);
                byte_phases(1'b0, CMD_FUNCTION_SET | {3'b000, lcd_cfg.eight_bit_mode,
                            lcd_cfg.dual_line, lcd_cfg.tall_font, 2'b00});
                byte_phases(1'b0, CMD_DISPLAY_ON | {6'b000000, lcd_cfg.cursor_on,
                            lcd_cfg.blink_on});
                byte_phases(1'b0, CMD_CLEAR);
            end
            OP_INSTR:  byte_phases(1'b0, cmd.value);
            OP_DATA:   byte_phases(1'b1, cmd.value);
            OP_CLEAR:  byte_phases(1'b0, CMD_CLEAR);
            OP_SET_POS: begin
                addr = ROW_BASE[cmd.row] + {2'b00, cmd.column};
                byte_phases(1'b0, CMD_DDRAM | addr);
            end
            default: ;
        endcase
        n = pending_phases.size() - before_n;
        if (n > 0) begin
            tail = pending_phases.pop_back();
            tail.last = 1'b1;
            last_bus = tail.bus_value;
            pending_phases.push_back(tail);
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] got);
        if (got !== exp_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_phases.size() == 0) begin
                $error("m_data: expected nothing, got %0h", m_data);
                fail_count++;
            end else begin
                want = pending_phases.pop_front();
                check_field("reg_select", 8'(want.reg_select), 8'(m_data.reg_select));
                check_field("read_write", 8'(want.read_write), 8'(m_data.read_write));
                check_field("enable", 8'(want.enable), 8'(m_data.enable));
                check_field("bus_value", want.bus_value, m_data.bus_value);
                check_field("last", 8'(want.last), 8'(m_data.last));
            end
        end
    end

    initial begin : receiver
        int run_left;
        logic level;
        run_left = 0;
        level = 1'b1;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
                run_left = 0;
            end else begin
                if (run_left == 0) begin
                    run_left = $urandom_range(1, 12);
                    level = ($urandom_range(0, 99) >= stall_pct);
                end
                m_ready <= level;
                run_left--;
            end
        end
    end

    task automatic send_cmd(input lcd_in_t cmd, output int n, output logic [7:0] last_bus);
        s_valid <= 1'b1;
        s_data <= cmd;
        do @(posedge aclk); while (!s_ready);
        plan_bus_phases(cmd, n, last_bus);
    endtask

    task automatic pace();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 15);
            if (gap_max > 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, gap_max)) @(posedge aclk);
            end
        end
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (pending_phases.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] v);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        case (idx)
            CFG_EIGHT_BIT:   lcd_cfg.eight_bit_mode = v[0];
            CFG_DUAL_LINE:   lcd_cfg.dual_line = v[0];
            CFG_TALL_FONT:   lcd_cfg.tall_font = v[0];
            CFG_CURSOR_ON:   lcd_cfg.cursor_on = v[0];
            CFG_BLINK_ON:    lcd_cfg.blink_on = v[0];
            CFG_PHASE_TICKS: lcd_cfg.phase_ticks = v;
            default: ;
        endcase
    endtask

    task automatic set_mode(input logic eight, input logic [TICK_W-1:0] ticks);
        settle();
        write_reg(CFG_EIGHT_BIT, CFG_DATA_W'(eight));
        write_reg(CFG_DUAL_LINE, CFG_DATA_W'($urandom_range(0, 1)));
        write_reg(CFG_TALL_FONT, CFG_DATA_W'($urandom_range(0, 1)));
        write_reg(CFG_CURSOR_ON, CFG_DATA_W'($urandom_range(0, 1)));
        write_reg(CFG_BLINK_ON, CFG_DATA_W'($urandom_range(0, 1)));
        write_reg(CFG_PHASE_TICKS, ticks);
    endtask

    function automatic lcd_in_t random_cmd();
        lcd_in_t c;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 8) c.operation = OP_INIT;
        else if (pick < 30) c.operation = OP_INSTR;
        else if (pick < 65) c.operation = OP_DATA;
        else if (pick < 72) c.operation = OP_CLEAR;
        else if (pick < 93) c.operation = OP_SET_POS;
        else c.operation = OP_RSVD_A + 3'($urandom_range(0, 2));
        c.value = 8'($urandom_range(0, 255));
        c.row = 2'($urandom_range(0, 3));
        c.column = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(40, 63))
                                               : 6'($urandom_range(0, 39));
        return c;
    endfunction

    task automatic run_random(input int count);
        int sent;
        int n;
        logic [7:0] lb;
        sent = 0;
        while (sent < count) begin
            send_cmd(random_cmd(), n, lb);
            if (n > 0) sent++;
            pace();
        end
    endtask

    function automatic step_t cmd_row(input logic [2:0] op, input logic [7:0] v,
                                      input logic [1:0] r, input logic [5:0] col,
                                      input logic typed = 1'b0, input logic [4:0] n = 5'd0,
                                      input logic [7:0] bus = 8'h00);
        step_t s;
        s = '0;
        s.op = op;
        s.value = v;
        s.row = r;
        s.column = col;
        s.typed = typed;
        s.exp_n = n;
        s.exp_bus = bus;
        return s;
    endfunction

    function automatic step_t cfg_row(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] v);
        step_t s;
        s = '0;
        s.is_cfg = 1'b1;
        s.reg_index = idx;
        s.wdata = v;
        return s;
    endfunction

    initial begin : stimulus
        step_t directed[$];
        lcd_in_t cmd;
        int n;
        logic [7:0] lb;

        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_EIGHT_BIT;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_data = '0;
        lcd_cfg.eight_bit_mode = 1'b0;
        lcd_cfg.dual_line = 1'b1;
        lcd_cfg.tall_font = 1'b0;
        lcd_cfg.cursor_on = 1'b0;
        lcd_cfg.blink_on = 1'b0;
        lcd_cfg.phase_ticks = PHASE_TICKS_RESET;
        held_bus = 8'h00;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        directed.push_back(cfg_row(CFG_PHASE_TICKS, CFG_DATA_W'(1)));
        directed.push_back(cmd_row(OP_INIT, 8'h00, 2'd0, 6'd0, 1'b1, 5'd24, CMD_CLEAR));
        directed.push_back(cmd_row(OP_INSTR, 8'h00, 2'd0, 6'd0));
        directed.push_back(cmd_row(OP_INSTR, 8'hFF, 2'd0, 6'd0, 1'b1, 5'd6, 8'h0F));
        directed.push_back(cmd_row(OP_DATA, 8'h00, 2'd0, 6'd0));
        directed.push_back(cmd_row(OP_DATA, 8'hFF, 2'd3, 6'd63, 1'b1, 5'd6, 8'h0F));
        directed.push_back(cmd_row(OP_DATA, 8'hA5, 2'd1, 6'd21));
        directed.push_back(cmd_row(OP_DATA, 8'h5A, 2'd2, 6'd42));
        directed.push_back(cmd_row(OP_CLEAR, 8'h00, 2'd0, 6'd0, 1'b1, 5'd6, CMD_CLEAR));
        directed.push_back(cmd_row(OP_SET_POS, 8'h00, 2'd0, 6'd0));
        directed.push_back(cmd_row(OP_SET_POS, 8'h00, 2'd1, 6'd39));
        directed.push_back(cmd_row(OP_SET_POS, 8'h00, 2'd2, 6'd63));
        directed.push_back(cmd_row(OP_SET_POS, 8'hFF, 2'd3, 6'd63, 1'b1, 5'd6, 8'h0F));
        directed.push_back(cmd_row(OP_RSVD_A, 8'h00, 2'd0, 6'd0, 1'b1, 5'd0));
        directed.push_back(cmd_row(OP_RSVD_B, 8'hFF, 2'd3, 6'd63, 1'b1, 5'd0));
        directed.push_back(cmd_row(OP_RSVD_C, 8'h5A, 2'd1, 6'd7, 1'b1, 5'd0));
        directed.push_back(cfg_row(CFG_EIGHT_BIT, CFG_DATA_W'(1)));
        directed.push_back(cfg_row(CFG_TALL_FONT, CFG_DATA_W'(1)));
        directed.push_back(cfg_row(CFG_CURSOR_ON, CFG_DATA_W'(1)));
        directed.push_back(cfg_row(CFG_BLINK_ON, CFG_DATA_W'(1)));
        directed.push_back(cmd_row(OP_INIT, 8'h00, 2'd0, 6'd0, 1'b1, 5'd12, CMD_CLEAR));
        directed.push_back(cmd_row(OP_DATA, 8'hFF, 2'd0, 6'd0, 1'b1, 5'd4, 8'hFF));
        directed.push_back(cmd_row(OP_INSTR, 8'h00, 2'd0, 6'd0));
        directed.push_back(cmd_row(OP_SET_POS, 8'h00, 2'd3, 6'd63, 1'b1, 5'd4, 8'h8F));
        directed.push_back(cfg_row(CFG_DUAL_LINE, CFG_DATA_W'(0)));
        directed.push_back(cfg_row(CFG_TALL_FONT, CFG_DATA_W'(0)));
        directed.push_back(cfg_row(CFG_CURSOR_ON, CFG_DATA_W'(0)));
        directed.push_back(cfg_row(CFG_BLINK_ON, CFG_DATA_W'(0)));
        directed.push_back(cmd_row(OP_INIT, 8'h00, 2'd0, 6'd0, 1'b1, 5'd12, CMD_CLEAR));
        directed.push_back(cfg_row(CFG_EIGHT_BIT, CFG_DATA_W'(0)));
        directed.push_back(cfg_row(CFG_DUAL_LINE, CFG_DATA_W'(1)));
        directed.push_back(cmd_row(OP_INIT, 8'h00, 2'd0, 6'd0, 1'b1, 5'd24, CMD_CLEAR));

        gap_max = 3;
        stall_pct = 20;
        foreach (directed[i]) begin
            if (directed[i].is_cfg) begin
                settle();
                write_reg(directed[i].reg_index, directed[i].wdata);
            end else begin
                cmd.operation = directed[i].op;
                cmd.value = directed[i].value;
                cmd.row = directed[i].row;
                cmd.column = directed[i].column;
                send_cmd(cmd, n, lb);
                if (directed[i].typed && n != directed[i].exp_n) begin
                    $error("phase count: expected %0d, got %0d", directed[i].exp_n, n);
                    fail_count++;
                end
                if (directed[i].typed && n > 0 && lb !== directed[i].exp_bus) begin
                    $error("last bus_value: expected %0h, got %0h", directed[i].exp_bus, lb);
                    fail_count++;
                end
                pace();
            end
        end

        // back to back, no stalls
        set_mode(1'b0, TICK_W'(1));
        gap_max = 0;
        stall_pct = 0;
        run_random(60);

        set_mode(1'b0, TICK_W'($urandom_range(1, 3)));
        gap_max = 10;
        stall_pct = 30;
        run_random(40);
        settle();
        run_random(40);

        // long receiver hold while commands keep coming
        set_mode(1'($urandom_range(0, 1)), TICK_W'(2));
        gap_max = 0;
        hold_req = 1'b1;
        run_random(30);

        set_mode(1'b1, TICK_W'($urandom_range(1, 2)));
        gap_max = 6;
        stall_pct = 70;
        run_random(80);

        settle();
        write_reg(CFG_PHASE_TICKS, TICKS_MAX);
        set_mode(1'b0, TICK_W'(300));
        gap_max = 4;
        stall_pct = 10;
        run_random(4);

        set_mode(1'($urandom_range(0, 1)), TICK_W'($urandom_range(1, 4)));
        gap_max = 8;
        stall_pct = 20;
        run_random(50);
        set_mode(1'b0, TICK_W'($urandom_range(1, 4)));
        stall_pct = 50;
        run_random(50);

        settle();
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+src
src/clbs_pkg.sv
src/clbs_front.sv
src/clbs_queue.sv
src/clbs_back.sv
src/char_lcd_bus_sequencer.sv
src/clbs_checker.sv
tb/tb_char_lcd_bus_sequencer.sv
